### src/bounding_volume_from_vertices_macros.svh
// assertion macros for the checker file
`ifndef BOUNDING_VOLUME_FROM_VERTICES_MACROS_SVH
`define BOUNDING_VOLUME_FROM_VERTICES_MACROS_SVH

// clocked check, switched off while reset is asserted
`define BVV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked check that also holds during reset
`define BVV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/bvv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bvv_pkg;

  localparam int FIELD_W        = 24;
  localparam int HALF_W         = 23;
  localparam int RAD_W          = 24;
  localparam int COORD_BITS_DEF = 24;
  localparam int CFG_AW         = 4;
  localparam int CFG_DW         = 32;

  // register map, word index
  typedef enum logic [1:0] {
    REG_SHAPE_MODE = 2'd0,
    REG_OFFSET_X   = 2'd1,
    REG_OFFSET_Y   = 2'd2,
    REG_OFFSET_Z   = 2'd3
  } bvv_reg_t;

  typedef enum logic {
    SHAPE_BOX    = 1'b0,
    SHAPE_SPHERE = 1'b1
  } bvv_shape_t;

  localparam logic signed [FIELD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [FIELD_W-1:0] COORD_MIN = 24'sh800000;

  typedef struct packed {
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
    logic                      last_vertex;
  } bvv_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] centre_x;
    logic signed [FIELD_W-1:0] centre_y;
    logic signed [FIELD_W-1:0] centre_z;
    logic [HALF_W-1:0]         half_x;
    logic [HALF_W-1:0]         half_y;
    logic [HALF_W-1:0]         half_z;
    logic [RAD_W-1:0]          radius;
  } bvv_out_t;

endpackage

`default_nettype wire

### src/bvv_axis_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module bvv_axis_lane import bvv_pkg::*; #(
  parameter int CB = COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      accept,
  input  logic                      seed,
  input  logic signed [FIELD_W-1:0] pos,
  input  logic signed [FIELD_W-1:0] offset,
  output logic signed [FIELD_W-1:0] centre,
  output logic [HALF_W-1:0]         half,
  output logic [2*CB-1:0]           sq
);

  localparam int XW = ((CB > FIELD_W) ? CB : FIELD_W) + 1;
  localparam int ZW = ((CB > HALF_W) ? CB : HALF_W) + 1;
  localparam logic signed [XW-1:0] IN_HI  = {{(XW-CB+1){1'b0}}, {(CB-1){1'b1}}};
  localparam logic signed [XW-1:0] IN_LO  = ~IN_HI;
  localparam logic signed [CB:0]   SUM_HI = {2'b00, {(CB-1){1'b1}}};
  localparam logic signed [CB:0]   SUM_LO = ~SUM_HI;
  localparam logic signed [XW-1:0] OUT_HI = {{(XW-FIELD_W+1){1'b0}}, {(FIELD_W-1){1'b1}}};
  localparam logic signed [XW-1:0] OUT_LO = ~OUT_HI;
  localparam logic [ZW-1:0]        HALF_HI = {{(ZW-HALF_W){1'b0}}, {HALF_W{1'b1}}};

  // field value into the working coordinate range
  function automatic logic signed [CB-1:0] sat_in(input logic signed [FIELD_W-1:0] x);
    logic signed [XW-1:0] e;
    e = {{(XW-FIELD_W){x[FIELD_W-1]}}, x};
    if (e > IN_HI)      sat_in = IN_HI[CB-1:0];
    else if (e < IN_LO) sat_in = IN_LO[CB-1:0];
    else                sat_in = e[CB-1:0];
  endfunction

  function automatic logic signed [CB-1:0] sat_cb(input logic signed [CB:0] x);
    if (x > SUM_HI)      sat_cb = SUM_HI[CB-1:0];
    else if (x < SUM_LO) sat_cb = SUM_LO[CB-1:0];
    else                 sat_cb = x[CB-1:0];
  endfunction

  logic signed [CB-1:0] v, off_c;
  logic signed [CB-1:0] min_r, max_r, a_r, b_r;
  logic signed [CB:0]   lo_sum, hi_sum, c_sum, c_half, diff;
  logic signed [XW-1:0] c_ext;
  logic [ZW-1:0]        h_ext;
  logic [CB-1:0]        d_r;
  logic signed [FIELD_W-1:0] centre_r, centre_nxt;
  logic [HALF_W-1:0]    half_r, half_nxt;
  logic [2*CB-1:0]      sq_r;

  assign v     = sat_in(pos);
  assign off_c = sat_in(offset);

  // running bounds
  always_ff @(posedge clk) begin
    if (accept) begin
      if (seed) begin
        min_r <= v;
        max_r <= v;
      end else begin
        if (v < min_r) min_r <= v;
        if (v > max_r) max_r <= v;
      end
    end
  end

  // bounds plus offset
  assign lo_sum = $signed({min_r[CB-1], min_r}) + $signed({off_c[CB-1], off_c});
  assign hi_sum = $signed({max_r[CB-1], max_r}) + $signed({off_c[CB-1], off_c});

  always_ff @(posedge clk) begin
    a_r <= sat_cb(lo_sum);
    b_r <= sat_cb(hi_sum);
  end

  // centre and extent
  assign c_sum  = $signed({a_r[CB-1], a_r}) + $signed({b_r[CB-1], b_r});
  assign c_half = c_sum >>> 1;
  assign c_ext  = {{(XW-CB){c_half[CB-1]}}, c_half[CB-1:0]};
  assign diff   = $signed({b_r[CB-1], b_r}) - $signed({a_r[CB-1], a_r});
  assign h_ext  = {{(ZW-CB+1){1'b0}}, diff[CB-1:1]};

  always_comb begin
    if (c_ext > OUT_HI)      centre_nxt = OUT_HI[FIELD_W-1:0];
    else if (c_ext < OUT_LO) centre_nxt = OUT_LO[FIELD_W-1:0];
    else                     centre_nxt = c_ext[FIELD_W-1:0];
    if (h_ext > HALF_HI) half_nxt = HALF_HI[HALF_W-1:0];
    else                 half_nxt = h_ext[HALF_W-1:0];
  end

  always_ff @(posedge clk) begin
    centre_r <= centre_nxt;
    half_r   <= half_nxt;
    d_r      <= diff[CB-1:0];
    sq_r     <= {{CB{1'b0}}, d_r} * {{CB{1'b0}}, d_r};
  end

  assign centre = centre_r;
  assign half   = half_r;
  assign sq     = sq_r;

endmodule

`default_nettype wire

### src/bvv_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module bvv_isqrt import bvv_pkg::*; #(
  parameter int CB = COORD_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*CB-1:0] n,
  output logic            done,
  output logic [CB-1:0]   root
);

  localparam int CW = $clog2(CB);
  localparam logic [CW-1:0] LAST_STEP = CW'(CB - 1);

  logic            busy_r, done_r;
  logic [CW-1:0]   cnt_r;
  logic [2*CB-1:0] n_r;
  logic [CB-1:0]   rem_r, rem_nxt;
  logic [CB-1:0]   root_r, root_nxt;
  logic [CB+1:0]   rem_sh, trial;
  logic            ge;

  // one root bit per cycle, two radicand bits brought down
  // the remainder fits CB bits up to the final step, which only needs the compare
  assign rem_sh   = {rem_r, n_r[2*CB-1 -: 2]};
  assign trial    = {root_r, 2'b01};
  assign ge       = (rem_sh >= trial);
  assign rem_nxt  = ge ? CB'(rem_sh - trial) : rem_sh[CB-1:0];
  assign root_nxt = {root_r[CB-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= n;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      n_r    <= {n_r[2*CB-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

### src/bounding_volume_from_vertices.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                        payload
// in_       input      in_valid / in_ready              bvv_in_t  (one vertex)
// out_      output     out_valid / out_ready            bvv_out_t (one per mesh)
// cfg (apb) input      psel penable pwrite paddr pready shape mode, x/y/z offsets
//
// ordinary vertices: one transaction per cycle, in_ready stays high
// last vertex: in_ready drops while the mesh is finished (offset bounds, centre
//   and extent, squares, merge, the bit-serial square root in sphere mode only)
// the result sits in an output register; the next mesh streams in meanwhile
//   and only the hand-over of its own result waits for out_ready
// reset (rst_n low, synchronous) clears control, config and the result valid

module bounding_volume_from_vertices import bvv_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bvv_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bvv_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int CB = COORD_BITS;
  localparam int RW = ((CB > RAD_W) ? CB : RAD_W) + 1;
  localparam logic [RW-1:0] RAD_HI = {{(RW-RAD_W){1'b0}}, {RAD_W{1'b1}}};

  typedef enum logic [6:0] {
    ST_RUN  = 7'b0000001,  // streaming vertices
    ST_BND  = 7'b0000010,  // offset bounds
    ST_CTR  = 7'b0000100,  // centre, extent
    ST_SQR  = 7'b0001000,  // squares per axis
    ST_SUM  = 7'b0010000,  // merge squares, launch root in sphere mode
    ST_ROOT = 7'b0100000,  // bit-serial square root
    ST_DONE = 7'b1000000   // hand result to the output register
  } state_t;

  state_t state_r, state_nxt;
  logic   awaiting_r, awaiting_nxt;
  logic   accept, out_load, root_start, root_done;
  logic   cfg_wr;
  logic   sphere_mode;

  logic                      shape_mode_r;
  logic signed [FIELD_W-1:0] off_r [3];

  logic signed [FIELD_W-1:0] lane_pos    [3];
  logic signed [FIELD_W-1:0] lane_centre [3];
  logic [HALF_W-1:0]         lane_half   [3];
  logic [2*CB-1:0]           lane_sq     [3];

  logic [2*CB+1:0] sq_sum;
  logic [CB-1:0]   root;
  logic [RW-1:0]   root_ext;
  logic [RAD_W-1:0] radius;

  logic     out_valid_r;
  bvv_out_t out_r;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_mode_r <= SHAPE_BOX;
      off_r[0]     <= '0;
      off_r[1]     <= '0;
      off_r[2]     <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SHAPE_MODE: shape_mode_r <= pwdata[0];
        REG_OFFSET_X:   off_r[0]     <= pwdata[FIELD_W-1:0];
        REG_OFFSET_Y:   off_r[1]     <= pwdata[FIELD_W-1:0];
        REG_OFFSET_Z:   off_r[2]     <= pwdata[FIELD_W-1:0];
        default:        ;
      endcase
    end
  end

  // readback, offsets sign extended
  always_comb begin
    unique case (paddr[3:2])
      REG_SHAPE_MODE: prdata = {{(CFG_DW-1){1'b0}}, shape_mode_r};
      REG_OFFSET_X:   prdata = {{(CFG_DW-FIELD_W){off_r[0][FIELD_W-1]}}, off_r[0]};
      REG_OFFSET_Y:   prdata = {{(CFG_DW-FIELD_W){off_r[1][FIELD_W-1]}}, off_r[1]};
      REG_OFFSET_Z:   prdata = {{(CFG_DW-FIELD_W){off_r[2][FIELD_W-1]}}, off_r[2]};
      default:        prdata = '0;
    endcase
  end

  assign sphere_mode = (shape_mode_r == SHAPE_SPHERE);

  // ---------------- input side ----------------
  // vertices are taken only while streaming; the finishing steps of a mesh
  // hold the bounds still
  assign in_ready = (state_r == ST_RUN);
  assign accept   = in_valid && in_ready;

  // first vertex after reset or after a last vertex seeds the bounds
  assign awaiting_nxt = accept ? in_data.last_vertex : awaiting_r;

  assign lane_pos[0] = in_data.pos_x;
  assign lane_pos[1] = in_data.pos_y;
  assign lane_pos[2] = in_data.pos_z;

  // one lane per axis: bounds, offset, centre, extent and its square
  for (genvar g = 0; g < 3; g++) begin : g_lane
    bvv_axis_lane #(.CB(CB)) u_lane (
      .clk    (clk),
      .accept (accept),
      .seed   (awaiting_r),
      .pos    (lane_pos[g]),
      .offset (off_r[g]),
      .centre (lane_centre[g]),
      .half   (lane_half[g]),
      .sq     (lane_sq[g])
    );
  end

  // ---------------- merge ----------------
  // quarter of the squared diagonal, exact floor of the sum over four
  assign sq_sum = {2'b00, lane_sq[0]} + {2'b00, lane_sq[1]} + {2'b00, lane_sq[2]};

  assign root_start = (state_r == ST_SUM) && sphere_mode;

  bvv_isqrt #(.CB(CB)) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .n     (sq_sum[2*CB+1:2]),
    .done  (root_done),
    .root  (root)
  );

  // radius clipped to its field for wide coordinates
  assign root_ext = {{(RW-CB){1'b0}}, root};
  assign radius   = (root_ext > RAD_HI) ? RAD_HI[RAD_W-1:0] : root_ext[RAD_W-1:0];

  // ---------------- sequencer ----------------
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN:  if (accept && in_data.last_vertex) state_nxt = ST_BND;
      ST_BND:  state_nxt = ST_CTR;
      ST_CTR:  state_nxt = ST_SQR;
      ST_SQR:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = sphere_mode ? ST_ROOT : ST_DONE;
      ST_ROOT: if (root_done) state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_RUN;
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_RUN;
      awaiting_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      awaiting_r <= awaiting_nxt;
    end
  end

  // ---------------- output register ----------------
  // holds one result transaction until out_ready takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.centre_x <= lane_centre[0];
      out_r.centre_y <= lane_centre[1];
      out_r.centre_z <= lane_centre[2];
      // box mode carries half extents, sphere mode the radius
      out_r.half_x   <= sphere_mode ? '0 : lane_half[0];
      out_r.half_y   <= sphere_mode ? '0 : lane_half[1];
      out_r.half_z   <= sphere_mode ? '0 : lane_half[2];
      out_r.radius   <= sphere_mode ? radius : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### src/bvv_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "bounding_volume_from_vertices_macros.svh"

module bvv_checker import bvv_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input bvv_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input bvv_out_t out_data
);

  // a stalled result holds
  `BVV_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

  // no result straight out of reset
  `BVV_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid, "result valid after reset")

  // the last vertex of a mesh stops the stream while the result is built
  `BVV_ASSERT(a_last_stalls, in_valid && in_ready && in_data.last_vertex |=> !in_ready, "vertex taken during mesh finish")

  // a new result is loaded only while the input side is held
  `BVV_ASSERT(a_load_busy, $rose(out_valid) |-> $past(!in_ready), "result appeared while streaming")

  // box and sphere outputs are exclusive
  `BVV_ASSERT(a_mode_fields, out_valid |-> (out_data.radius == '0) || (out_data.half_x == '0 && out_data.half_y == '0 && out_data.half_z == '0), "both half extents and radius set")

endmodule

bind bounding_volume_from_vertices bvv_checker u_bvv_checker (.*);

`default_nettype wire
